// File: design/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths, types and codes shared by the ray / sphere intersection time unit.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Position relative to the sphere center along z needs one extra bit.
    localparam int ZW  = DATA_WIDTH + 1;
    // Products of two ZW-bit operands.
    localparam int PW  = 2 * ZW;
    // Quadratic coefficients a, b, c.
    localparam int BW  = 2 * DATA_WIDTH + 4;
    // Limb width of the wide multiplier (three limbs per operand).
    localparam int LW  = (BW + 2) / 3;
    // Magnitude of a wide product.
    localparam int MW  = 2 * BW;
    // Discriminant, signed, and its nonnegative remainder in the square root.
    localparam int DSW = MW + 3;
    localparam int RMW = DSW - 1;
    // Integer square root bits.
    localparam int SQB = BW;
    // Root numerators and denominators.
    localparam int QW  = BW + 2;
    // Division remainder.
    localparam int RW  = QW + DATA_WIDTH + FRAC_BITS;
    // Result time width.
    localparam int TW  = DATA_WIDTH - 1;
    // Latency of the wide multiplier.
    localparam int WMUL_LAT = 4;

    localparam logic [DATA_WIDTH-1:0] RADIUS_RESET = DATA_WIDTH'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [BW-1:0] a;
        logic signed [BW-1:0] b;
        logic signed [BW-1:0] c;
    } t_abc;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_OK,
        ST_OVF
    } t_root_st;

    typedef struct packed {
        logic          hit;
        logic [TW-1:0] time_res;
    } t_res;

endpackage

// File: design/rsi_ray_if.sv
// ----------------------------------------------------------------------------
// rsi_ray_if
// Ray channel: start position and velocity, valid / ready.
// ----------------------------------------------------------------------------
interface rsi_ray_if import rsi_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] pos_x;
    logic signed [DATA_WIDTH-1:0] pos_y;
    logic signed [DATA_WIDTH-1:0] pos_z;
    logic signed [DATA_WIDTH-1:0] vel_x;
    logic signed [DATA_WIDTH-1:0] vel_y;
    logic signed [DATA_WIDTH-1:0] vel_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        output ready
    );
endinterface

// File: design/rsi_res_if.sv
// ----------------------------------------------------------------------------
// rsi_res_if
// Result channel: hit flag and intersection time, valid / ready.
// ----------------------------------------------------------------------------
interface rsi_res_if import rsi_pkg::*; ();
    logic          valid;
    logic          ready;
    logic          hit;
    logic [TW-1:0] time_res;

    modport source (
        output valid, hit, time_res,
        input  ready
    );
    modport sink (
        input  valid, hit, time_res,
        output ready
    );
endinterface

// File: design/rsi_cfg_if.sv
// ----------------------------------------------------------------------------
// rsi_cfg_if
// Configuration write channel for the sphere radius.
// ----------------------------------------------------------------------------
interface rsi_cfg_if import rsi_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] radius;

    modport source (
        output valid, radius,
        input  ready
    );
    modport sink (
        input  valid, radius,
        output ready
    );
endinterface

// File: design/rsi_quad.sv
// ----------------------------------------------------------------------------
// rsi_quad
// Three stages: shift z to the sphere center, form the products, sum a, b, c.
// ----------------------------------------------------------------------------
module rsi_quad import rsi_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [DATA_WIDTH-1:0] i_pos_x,
    input  logic signed [DATA_WIDTH-1:0] i_pos_y,
    input  logic signed [DATA_WIDTH-1:0] i_pos_z,
    input  logic signed [DATA_WIDTH-1:0] i_vel_x,
    input  logic signed [DATA_WIDTH-1:0] i_vel_y,
    input  logic signed [DATA_WIDTH-1:0] i_vel_z,
    input  logic signed [DATA_WIDTH-1:0] i_radius,
    output logic                         o_valid,
    output t_abc                         o_abc
);

    logic                 r_v1, r_v2, r_v3;
    logic signed [ZW-1:0] r_x, r_y, r_vx, r_vy, r_vz, r_z0, r_r;
    logic signed [PW-1:0] r_vxx, r_vyy, r_vzz, r_vzz0, r_vxpx, r_vypy;
    logic signed [PW-1:0] r_z0z0, r_rr, r_xx, r_yy;
    t_abc                 r_abc, n_abc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= ZW'(i_pos_x);
            r_y  <= ZW'(i_pos_y);
            r_vx <= ZW'(i_vel_x);
            r_vy <= ZW'(i_vel_y);
            r_vz <= ZW'(i_vel_z);
            r_r  <= ZW'(i_radius);
            r_z0 <= ZW'(i_pos_z) - ZW'(i_radius);

            r_vxx  <= r_vx * r_vx;
            r_vyy  <= r_vy * r_vy;
            r_vzz  <= r_vz * r_vz;
            r_vzz0 <= r_vz * r_z0;
            r_vxpx <= r_vx * r_x;
            r_vypy <= r_vy * r_y;
            r_z0z0 <= r_z0 * r_z0;
            r_rr   <= r_r * r_r;
            r_xx   <= r_x * r_x;
            r_yy   <= r_y * r_y;

            r_abc <= n_abc;
        end
    end

    always_comb begin
        n_abc.a = BW'(r_vxx) + BW'(r_vyy) + BW'(r_vzz);
        n_abc.b = (BW'(r_vzz0) + BW'(r_vxpx) + BW'(r_vypy)) <<< 1;
        n_abc.c = BW'(r_z0z0) - BW'(r_rr) + BW'(r_xx) + BW'(r_yy);
    end

    assign o_valid = r_v3;
    assign o_abc   = r_abc;

endmodule

// File: design/rsi_wmul.sv
// ----------------------------------------------------------------------------
// rsi_wmul
// Four-stage signed multiplier for the wide coefficients. Returns the product
// magnitude and its sign: operands are split into three limbs each.
// ----------------------------------------------------------------------------
module rsi_wmul import rsi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [BW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic [MW-1:0]        o_mag,
    output logic                 o_neg
);

    localparam int XW = 3 * LW;

    logic [XW-1:0]     r_ma, r_mb;
    logic              r_neg_a, r_neg_b, r_neg_c, r_neg_d;
    logic [2*LW-1:0]   r_pp [3][3];
    logic [2*XW-1:0]   r_row [3];
    logic [2*XW-1:0]   r_sum;
    logic [2*XW-1:0]   n_row [3];
    logic [2*XW-1:0]   n_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_row[i] = (2*XW)'(r_pp[i][0])
                     + ((2*XW)'(r_pp[i][1]) << LW)
                     + ((2*XW)'(r_pp[i][2]) << (2*LW));
        end
        n_sum = r_row[0] + (r_row[1] << LW) + (r_row[2] << (2*LW));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma    <= XW'($unsigned(i_a[BW-1] ? -i_a : i_a));
            r_mb    <= XW'($unsigned(i_b[BW-1] ? -i_b : i_b));
            r_neg_a <= i_a[BW-1] ^ i_b[BW-1];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pp[i][j] <= r_ma[i*LW +: LW] * r_mb[j*LW +: LW];
                end
            end
            r_neg_b <= r_neg_a;
            r_row   <= n_row;
            r_neg_c <= r_neg_b;
            r_sum   <= n_sum;
            r_neg_d <= r_neg_c;
        end
    end

    assign o_mag = r_sum[MW-1:0];
    assign o_neg = r_neg_d;

endmodule

// File: design/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Forms the discriminant and takes its integer square root, one result bit per
// pipeline stage. The coefficients travel alongside.
// ----------------------------------------------------------------------------
module rsi_sqrt import rsi_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [MW-1:0]  i_bb,
    input  logic [MW-1:0]  i_ac,
    input  logic           i_ac_neg,
    input  t_abc           i_abc,
    output logic           o_valid,
    output logic [SQB-1:0] o_root,
    output logic           o_kill,
    output t_abc           o_abc
);

    logic [DSW-1:0] w_bbx, w_acx, w_disc;
    logic [RMW-1:0] r_rem  [SQB];
    logic [SQB-1:0] r_res  [SQB+1];
    logic           r_kill [SQB+1];
    t_abc           r_abc  [SQB+1];
    logic           r_v    [SQB+1];

    always_comb begin
        w_bbx  = DSW'(i_bb);
        w_acx  = DSW'(i_ac) << 2;
        w_disc = i_ac_neg ? (w_bbx + w_acx) : (w_bbx - w_acx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    // A negative discriminant or a zero a kills the ray; a negative discriminant also makes the root run on zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_disc[DSW-1] ? '0 : w_disc[RMW-1:0];
            r_res[0]  <= '0;
            r_kill[0] <= w_disc[DSW-1] || (i_abc.a == '0);
            r_abc[0]  <= i_abc;
        end
    end

    for (genvar j = 0; j < SQB; j++) begin : g_stage
        localparam int K = SQB - 1 - j;
        logic [RMW-1:0] w_trial;
        logic           w_take;

        // Setting bit K grows the square by res*2^(K+1) + 2^(2K).
        always_comb begin
            w_trial = (RMW'(r_res[j]) << (K + 1)) | (RMW'(1) << (2 * K));
            w_take  = r_rem[j] >= w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[j+1]  <= w_take ? (r_res[j] | (SQB'(1) << K)) : r_res[j];
                r_kill[j+1] <= r_kill[j];
                r_abc[j+1]  <= r_abc[j];
            end
        end

        if (j < SQB - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1] <= w_take ? (r_rem[j] - w_trial) : r_rem[j];
                end
            end
        end
    end

    assign o_valid = r_v[SQB];
    assign o_root  = r_res[SQB];
    assign o_kill  = r_kill[SQB];
    assign o_abc   = r_abc[SQB];

endmodule

// File: design/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// Evaluates one root as num/den in Q.FRAC_BITS: sign and zero checks, an
// overflow compare, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module rsi_div import rsi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [QW-1:0] i_num,
    input  logic signed [QW-1:0] i_den,
    output logic                 o_valid,
    output t_root_st             o_st,
    output logic [TW-1:0]        o_t
);

    logic           r_v0, r_bad0;
    logic [RW-1:0]  r_n0;
    logic [QW-1:0]  r_d0;
    logic [RW-1:0]  r_rem [TW];
    logic [QW-1:0]  r_d   [TW];
    logic [TW-1:0]  r_q   [TW+1];
    logic           r_bad [TW+1];
    logic           r_ovf [TW+1];
    logic           r_v   [TW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v0   <= i_valid;
            r_v[0] <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // A root counts only when numerator and denominator are nonzero
            // and share a sign.
            r_bad0 <= (i_num == '0) || (i_den == '0) || (i_num[QW-1] != i_den[QW-1]);
            r_n0   <= RW'($unsigned(i_num[QW-1] ? -i_num : i_num)) << FRAC_BITS;
            r_d0   <= $unsigned(i_den[QW-1] ? -i_den : i_den);

            r_rem[0] <= r_n0;
            r_d[0]   <= r_d0;
            r_q[0]   <= '0;
            r_bad[0] <= r_bad0;
            r_ovf[0] <= r_n0 >= (RW'(r_d0) << TW);
        end
    end

    for (genvar j = 0; j < TW; j++) begin : g_stage
        localparam int I = TW - 1 - j;
        logic [RW-1:0] w_sub;
        logic          w_take;

        always_comb begin
            w_sub  = RW'(r_d[j]) << I;
            w_take = r_rem[j] >= w_sub;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j+1]   <= w_take ? (r_q[j] | (TW'(1) << I)) : r_q[j];
                r_bad[j+1] <= r_bad[j];
                r_ovf[j+1] <= r_ovf[j];
            end
        end

        if (j < TW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1] <= w_take ? (r_rem[j] - w_sub) : r_rem[j];
                    r_d[j+1]   <= r_d[j];
                end
            end
        end
    end

    always_comb begin
        if (r_bad[TW]) begin
            o_st = ST_NONE;
        end else if (r_ovf[TW]) begin
            o_st = ST_OVF;
        end else if (r_q[TW] == '0) begin
            o_st = ST_NONE;
        end else begin
            o_st = ST_OK;
        end
    end

    assign o_valid = r_v[TW];
    assign o_t     = r_q[TW];

endmodule

// File: design/ray_sphere_intersect_time_unit.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_time_unit
// Time at which a ray meets a sphere with its vertex at the origin, using the
// numerically stable quadratic root, in fixed point.
//
//   Channel   Dir  Payload                                 Transfer
//   i_ray     in   pos_x/y/z, vel_x/y/z (signed Q16.16)    valid & ready
//   o_res     out  hit, time_res (unsigned Q15.16)         valid & ready
//   i_cfg     in   radius (signed Q16.16)                  valid & ready
//
// One ray per cycle while the output queue has room; the bit-serial square root
// stages set most of the latency.
// Reset clears all valid bits and the output queue and sets radius to 1.0.
// The whole pipeline advances together; it halts only while the two-entry
// output queue is full, and i_ray.ready is driven from that queue's count.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_time_unit import rsi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rsi_ray_if.sink i_ray,
    rsi_res_if.source o_res,
    rsi_cfg_if.sink i_cfg
);

    localparam int QDEPTH = 2;

    logic                   w_en;
    logic [DATA_WIDTH-1:0]  r_radius;

    logic                   w_q_valid;
    t_abc                   w_q_abc;
    t_abc                   r_dly_abc [WMUL_LAT];
    logic                   r_dly_v   [WMUL_LAT];
    logic [MW-1:0]          w_bb, w_ac;
    logic                   w_bb_neg, w_ac_neg;

    logic                   w_s_valid, w_s_kill;
    logic [SQB-1:0]         w_s_root;
    t_abc                   w_s_abc;

    logic signed [QW-1:0]   w_sx, w_bx, w_two_a, w_two_c, w_q;
    logic signed [QW-1:0]   n_n1, n_d1, n_n2, n_d2;
    logic signed [QW-1:0]   r_n1, r_d1, r_n2, r_d2;
    logic                   w_b_pos, r_vs;

    logic                   w_v1, w_v2, w_tail_v;
    t_root_st               w_st1, w_st2;
    logic [TW-1:0]          w_t1, w_t2;
    t_res                   w_res;

    t_res                   r_buf [QDEPTH];
    logic [1:0]             r_cnt;
    logic                   w_push, w_pop;

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg.valid) begin
            r_radius <= i_cfg.radius;
        end
    end

    assign w_en        = (r_cnt != 2'(QDEPTH));
    assign i_ray.ready = w_en;

    rsi_quad u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_ray.valid),
        .i_pos_x (i_ray.pos_x),
        .i_pos_y (i_ray.pos_y),
        .i_pos_z (i_ray.pos_z),
        .i_vel_x (i_ray.vel_x),
        .i_vel_y (i_ray.vel_y),
        .i_vel_z (i_ray.vel_z),
        .i_radius(r_radius),
        .o_valid (w_q_valid),
        .o_abc   (w_q_abc)
    );

    rsi_wmul u_mul_bb (
        .i_clk(i_clk),
        .i_en (w_en),
        .i_a  (w_q_abc.b),
        .i_b  (w_q_abc.b),
        .o_mag(w_bb),
        .o_neg(w_bb_neg)
    );

    rsi_wmul u_mul_ac (
        .i_clk(i_clk),
        .i_en (w_en),
        .i_a  (w_q_abc.a),
        .i_b  (w_q_abc.c),
        .o_mag(w_ac),
        .o_neg(w_ac_neg)
    );

    // Coefficients wait beside the multipliers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WMUL_LAT; i++) begin
                r_dly_v[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_dly_v[0] <= w_q_valid;
            for (int i = 1; i < WMUL_LAT; i++) begin
                r_dly_v[i] <= r_dly_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_abc[0] <= w_q_abc;
            for (int i = 1; i < WMUL_LAT; i++) begin
                r_dly_abc[i] <= r_dly_abc[i-1];
            end
        end
    end

    // b*b is never negative, so its sign only guards the pairing.
    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_dly_v[WMUL_LAT-1]),
        .i_bb    (w_bb_neg ? '0 : w_bb),
        .i_ac    (w_ac),
        .i_ac_neg(w_ac_neg),
        .i_abc   (r_dly_abc[WMUL_LAT-1]),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_kill  (w_s_kill),
        .o_abc   (w_s_abc)
    );

    // Root setup: pick the stable form by the sign of b. A zero numerator makes
    // a root count as absent, which covers killed rays and a void second root.
    always_comb begin
        w_sx    = QW'(w_s_root);
        w_bx    = QW'($signed(w_s_abc.b));
        w_two_a = QW'($signed(w_s_abc.a)) <<< 1;
        w_two_c = QW'($signed(w_s_abc.c)) <<< 1;
        w_b_pos = !w_s_abc.b[BW-1] && (w_s_abc.b != '0);
        w_q     = w_b_pos ? (-w_bx - w_sx) : (w_sx - w_bx);
        if (w_b_pos) begin
            n_n1 = w_q;
            n_d1 = w_two_a;
            n_n2 = w_two_c;
            n_d2 = w_q;
        end else begin
            n_n1 = w_two_c;
            n_d1 = w_q;
            // With c zero the first root is exactly zero and the second is void.
            n_n2 = (w_s_abc.c == '0) ? '0 : w_q;
            n_d2 = w_two_a;
        end
        if (w_s_kill) begin
            n_n1 = '0;
            n_n2 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
        end else if (w_en) begin
            r_vs <= w_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n1 <= n_n1;
            r_d1 <= n_d1;
            r_n2 <= n_n2;
            r_d2 <= n_d2;
        end
    end

    rsi_div u_div1 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r_vs),
        .i_num  (r_n1),
        .i_den  (r_d1),
        .o_valid(w_v1),
        .o_st   (w_st1),
        .o_t    (w_t1)
    );

    rsi_div u_div2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r_vs),
        .i_num  (r_n2),
        .i_den  (r_d2),
        .o_valid(w_v2),
        .o_st   (w_st2),
        .o_t    (w_t2)
    );

    assign w_tail_v = w_v1 && w_v2;

    // The second root is tried only when the first is not positive; an
    // overflowing first root ends the search.
    always_comb begin
        w_res.hit      = 1'b0;
        w_res.time_res = '0;
        case (w_st1)
            ST_OK: begin
                w_res.hit      = 1'b1;
                w_res.time_res = w_t1;
            end
            ST_NONE: begin
                if (w_st2 == ST_OK) begin
                    w_res.hit      = 1'b1;
                    w_res.time_res = w_t2;
                end
            end
            default: begin
                w_res.hit = 1'b0;
            end
        endcase
    end

    // Two-entry output queue; entry 0 is the head.
    assign w_push = w_tail_v && w_en;
    assign w_pop  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_buf[0] <= (r_cnt == 2'd1) ? w_res : r_buf[1];
            if (w_push && r_cnt == 2'd2) begin
                r_buf[1] <= w_res;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_buf[0] <= w_res;
            end else begin
                r_buf[1] <= w_res;
            end
        end
    end

    assign o_res.valid    = (r_cnt != 2'd0);
    assign o_res.hit      = r_buf[0].hit;
    assign o_res.time_res = r_buf[0].time_res;

endmodule

// File: design/rsi_checker.sv
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks on the intersection time unit, bound to its top level.
// ----------------------------------------------------------------------------
module rsi_checker import rsi_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic          i_hit,
    input logic [TW-1:0] i_time_res
);

    // A miss always reports a zero time.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_hit) |-> (i_time_res == '0))
        else $error("miss with nonzero time");

    // Input backpressure only appears while results are waiting.
    a_ready_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending result");

    // Reset empties the result side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_hit) && $stable(i_time_res)))
        else $error("stalled result changed");

endmodule

bind ray_sphere_intersect_time_unit rsi_checker u_rsi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_ray.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_hit      (o_res.hit),
    .i_time_res (o_res.time_res)
);
